// ===== sv/fisr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants and helpers for the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

   typedef logic [31:0] fp32_type;

   localparam fp32_type MAGIC_GUESS  = 32'h5f3759df;
   localparam fp32_type CANON_NAN    = 32'h7fc00000;
   localparam fp32_type ONE_HALF     = 32'h3f000000;
   localparam fp32_type THREE_HALVES = 32'h3fc00000;
   localparam int       NUM_STAGES   = 11;

   // leading zero count of a 48-bit word, 48 when zero
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] cnt;
      cnt = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            cnt = 6'(47 - i);
         end
      end
      return cnt;
   endfunction

endpackage
`default_nettype wire

// ===== sv/fisr_fmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_fmul
// Two-stage single-precision multiplier, round to nearest even, subnormals.
// ----------------------------------------------------------------------------
module fisr_fmul (
   input  wire logic              clock,
   input  wire logic              en_a,
   input  wire logic              en_b,
   input  wire fisr_pkg::fp32_type a_bits,
   input  wire fisr_pkg::fp32_type b_bits,
   output fisr_pkg::fp32_type     y_bits
);

   // stage A: unpack and multiply
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic [23:0] ma, mb;
   logic [7:0]  eae, ebe;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic        sign_in, nan_in, inf_in, zero_in;
   logic [9:0]  es_in;
   logic [47:0] p_in;

   logic        sign_ff, nan_ff, inf_ff, zero_ff;
   logic [9:0]  es_ff;
   logic [47:0] p_ff;

   always_comb begin
      ea      = a_bits[30:23];
      eb      = b_bits[30:23];
      fa      = a_bits[22:0];
      fb      = b_bits[22:0];
      ma      = {ea != 8'd0, fa};
      mb      = {eb != 8'd0, fb};
      eae     = (ea == 8'd0) ? 8'd1 : ea;
      ebe     = (eb == 8'd0) ? 8'd1 : eb;
      a_nan   = (ea == 8'hff) && (fa != 23'd0);
      b_nan   = (eb == 8'hff) && (fb != 23'd0);
      a_inf   = (ea == 8'hff) && (fa == 23'd0);
      b_inf   = (eb == 8'hff) && (fb == 23'd0);
      a_zero  = (a_bits[30:0] == 31'd0);
      b_zero  = (b_bits[30:0] == 31'd0);
      sign_in = a_bits[31] ^ b_bits[31];
      nan_in  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf_in  = a_inf | b_inf;
      zero_in = a_zero | b_zero;
      es_in   = {2'b0, eae} + {2'b0, ebe};
      p_in    = ma * mb;
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         sign_ff <= sign_in;
         nan_ff  <= nan_in;
         inf_ff  <= inf_in;
         zero_ff <= zero_in;
         es_ff   <= es_in;
         p_ff    <= p_in;
      end
   end

   // stage B: normalise and round
   logic [5:0]         lz;
   logic signed [11:0] e_s, k;
   logic [10:0]        rs;
   logic [47:0]        x, mask;
   logic               sticky, inc;
   logic [7:0]         efield;
   logic [30:0]        base;
   fisr_pkg::fp32_type y_in;
   fisr_pkg::fp32_type y_ff;

   always_comb begin
      lz     = fisr_pkg::lzc48(p_ff);
      e_s    = $signed({2'b0, es_ff}) - 12'sd126 - $signed({6'b0, lz});
      k      = $signed({6'b0, lz}) + e_s - 12'sd1;
      rs     = 11'(-k);
      mask   = '0;
      sticky = 1'b0;
      x      = p_ff;
      efield = 8'd0;
      if (e_s >= 12'sd1) begin
         x      = p_ff << lz;
         efield = e_s[7:0];
      end else if (k >= 12'sd0) begin
         x = p_ff << k[5:0];
      end else if (rs >= 11'd48) begin
         x      = '0;
         sticky = |p_ff;
      end else begin
         mask   = (48'h1 << rs[5:0]) - 48'h1;
         x      = p_ff >> rs[5:0];
         sticky = |(p_ff & mask);
      end
      inc  = x[23] & ((|x[22:0]) | sticky | x[24]);
      base = {efield, x[46:24]};
      priority if (nan_ff) begin
         y_in = fisr_pkg::CANON_NAN;
      end else if (inf_ff) begin
         y_in = {sign_ff, 8'hff, 23'd0};
      end else if (zero_ff) begin
         y_in = {sign_ff, 31'd0};
      end else if (e_s >= 12'sd255) begin
         y_in = {sign_ff, 8'hff, 23'd0};
      end else begin
         y_in = {sign_ff, base + {30'd0, inc}};
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         y_ff <= y_in;
      end
   end

   assign y_bits = y_ff;

endmodule
`default_nettype wire

// ===== sv/fisr_fadd.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_fadd
// Two-stage single-precision adder, round to nearest even, subnormals.
// ----------------------------------------------------------------------------
module fisr_fadd (
   input  wire logic              clock,
   input  wire logic              en_a,
   input  wire logic              en_b,
   input  wire fisr_pkg::fp32_type a_bits,
   input  wire fisr_pkg::fp32_type b_bits,
   output fisr_pkg::fp32_type     y_bits
);

   // stage A: order by magnitude and align
   fisr_pkg::fp32_type big, sml;
   logic [7:0]  eb_raw, es_raw, eb_e, es_e, d;
   logic [4:0]  dc;
   logic [26:0] mbx, shd, msk;
   logic        a_nan, b_nan, a_inf, b_inf;
   logic        sign_in, sub_in, nan_in, inf_in, isign_in, zsign_in;
   logic [26:0] mb_in, al_in;

   logic        sign_ff, sub_ff, nan_ff, inf_ff, isign_ff, zsign_ff;
   logic [7:0]  exp_ff;
   logic [26:0] mb_ff, al_ff;

   always_comb begin
      a_nan  = (a_bits[30:23] == 8'hff) && (a_bits[22:0] != 23'd0);
      b_nan  = (b_bits[30:23] == 8'hff) && (b_bits[22:0] != 23'd0);
      a_inf  = (a_bits[30:23] == 8'hff) && (a_bits[22:0] == 23'd0);
      b_inf  = (b_bits[30:23] == 8'hff) && (b_bits[22:0] == 23'd0);
      if (a_bits[30:0] >= b_bits[30:0]) begin
         big = a_bits;
         sml = b_bits;
      end else begin
         big = b_bits;
         sml = a_bits;
      end
      eb_raw   = big[30:23];
      es_raw   = sml[30:23];
      eb_e     = (eb_raw == 8'd0) ? 8'd1 : eb_raw;
      es_e     = (es_raw == 8'd0) ? 8'd1 : es_raw;
      d        = eb_e - es_e;
      dc       = (d > 8'd27) ? 5'd28 : d[4:0];
      mbx      = {es_raw != 8'd0, sml[22:0], 3'b0};
      shd      = mbx >> dc;
      msk      = (27'h1 << dc) - 27'h1;
      al_in    = {shd[26:1], shd[0] | (|(mbx & msk))};
      mb_in    = {eb_raw != 8'd0, big[22:0], 3'b0};
      sign_in  = big[31];
      sub_in   = a_bits[31] ^ b_bits[31];
      nan_in   = a_nan | b_nan | (a_inf & b_inf & (a_bits[31] != b_bits[31]));
      inf_in   = a_inf | b_inf;
      isign_in = a_inf ? a_bits[31] : b_bits[31];
      zsign_in = a_bits[31] & b_bits[31];
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         sign_ff  <= sign_in;
         sub_ff   <= sub_in;
         nan_ff   <= nan_in;
         inf_ff   <= inf_in;
         isign_ff <= isign_in;
         zsign_ff <= zsign_in;
         exp_ff   <= eb_e;
         mb_ff    <= mb_in;
         al_ff    <= al_in;
      end
   end

   // stage B: add, normalise, round
   logic [27:0]        s;
   logic [26:0]        r;
   logic [4:0]         lz;
   logic [7:0]         emax, sh;
   logic [8:0]         e;
   logic [7:0]         efield;
   logic               inc;
   fisr_pkg::fp32_type y_in;
   fisr_pkg::fp32_type y_ff;

   always_comb begin
      s    = sub_ff ? ({1'b0, mb_ff} - {1'b0, al_ff}) : ({1'b0, mb_ff} + {1'b0, al_ff});
      lz   = 5'(fisr_pkg::lzc48({s[26:0], 21'd0}));
      emax = exp_ff - 8'd1;
      sh   = ({3'd0, lz} < emax) ? {3'd0, lz} : emax;
      if (s[27]) begin
         r = {s[27:2], s[1] | s[0]};
         e = {1'b0, exp_ff} + 9'd1;
      end else begin
         r = s[26:0] << sh;
         e = {1'b0, exp_ff} - {1'b0, sh};
      end
      efield = r[26] ? e[7:0] : 8'd0;
      inc    = r[2] & (r[1] | r[0] | r[3]);
      priority if (nan_ff) begin
         y_in = fisr_pkg::CANON_NAN;
      end else if (inf_ff) begin
         y_in = {isign_ff, 8'hff, 23'd0};
      end else if (s == 28'd0) begin
         y_in = {zsign_ff, 31'd0};
      end else if (e >= 9'd255) begin
         y_in = {sign_ff, 8'hff, 23'd0};
      end else begin
         y_in = {sign_ff, {efield, r[25:3]} + {30'd0, inc}};
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         y_ff <= y_in;
      end
   end

   assign y_bits = y_ff;

endmodule
`default_nettype wire

// ===== sv/fast_inverse_square_root_unit.sv =====
`default_nettype none
// Depth: 11 register stages; rsp_valid rises when an accepted item reaches the last stage.
// Throughput: one item per cycle unless rsp_stall holds the output; an input register
// and five two-stage float units in series set the depth.
// Stalls ripple back only through occupied stages; bubbles are squeezed out.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// fast_inverse_square_root_unit
// Magic-constant guess refined by one Newton step, single precision.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_operand_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_result_bits
);

   localparam int N = fisr_pkg::NUM_STAGES;

   logic [N:1]         v_ff;
   logic [N:1]         en;
   fisr_pkg::fp32_type x_ff;
   fisr_pkg::fp32_type g_in;
   fisr_pkg::fp32_type g_ff [1:9];
   fisr_pkg::fp32_type half, t1, t2, t3, r;

   always_comb begin
      en[N] = !v_ff[N] || !rsp_stall;
      for (int k = N - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k + 1];
      end
   end

   assign req_stall = !en[1];
   assign g_in      = fisr_pkg::MAGIC_GUESS - {req_operand_bits[31], req_operand_bits[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= N; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x_ff    <= req_operand_bits;
         g_ff[1] <= g_in;
      end
      for (int k = 2; k <= 9; k++) begin
         if (en[k]) begin
            g_ff[k] <= g_ff[k - 1];
         end
      end
   end

   fisr_fmul u_mul_half (
      .clock (clock), .en_a (en[2]), .en_b (en[3]),
      .a_bits (x_ff), .b_bits (fisr_pkg::ONE_HALF), .y_bits (half)
   );

   fisr_fmul u_mul_t1 (
      .clock (clock), .en_a (en[4]), .en_b (en[5]),
      .a_bits (half), .b_bits (g_ff[3]), .y_bits (t1)
   );

   fisr_fmul u_mul_t2 (
      .clock (clock), .en_a (en[6]), .en_b (en[7]),
      .a_bits (t1), .b_bits (g_ff[5]), .y_bits (t2)
   );

   fisr_fadd u_sub_t3 (
      .clock (clock), .en_a (en[8]), .en_b (en[9]),
      .a_bits (fisr_pkg::THREE_HALVES), .b_bits ({~t2[31], t2[30:0]}), .y_bits (t3)
   );

   fisr_fmul u_mul_r (
      .clock (clock), .en_a (en[10]), .en_b (en[11]),
      .a_bits (g_ff[9]), .b_bits (t3), .y_bits (r)
   );

   assign rsp_valid       = v_ff[N];
   assign rsp_result_bits = r;

`ifndef NO_ASSERTIONS
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
   a_free_out_takes : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with free output");
   a_full_stalls : assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && rsp_stall |-> req_stall)
      else $error("full pipe took an item");
   a_canon_nan : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_bits[30:23] == 8'hff) && (rsp_result_bits[22:0] != 23'd0)
      |-> rsp_result_bits == fisr_pkg::CANON_NAN)
      else $error("non-canonical NaN");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams single-precision bit patterns through the reciprocal square root
// unit under varied idling and stalling; results are checked bit for bit in
// order against an integer model of the float guess and Newton step.
// ----------------------------------------------------------------------------
module tb;

   class rsqrt_scoreboard;
      fisr_pkg::fp32_type expected_results[$];
      int                 mismatches = 0;

      function automatic fisr_pkg::fp32_type round_pack(bit s, bit [127:0] mag, int e);
         int         p;
         int         sh;
         int         q;
         bit [127:0] m;
         bit         g;
         bit         st;
         if (mag == 0) return {s, 31'b0};
         p = 0;
         for (int i = 0; i < 128; i++) if (mag[i]) p = i;
         sh = p - 23;
         if (sh < -149 - e) sh = -149 - e;
         if (sh <= 0) begin
            m = mag << (-sh);
         end else if (sh > 128) begin
            m = 0;
         end else begin
            m  = mag >> sh;
            g  = mag[sh-1];
            st = (mag & ((128'b1 << (sh - 1)) - 1)) != 0;
            if (g && (st || m[0])) m = m + 1;
         end
         q = e + sh;
         if (m[24]) begin
            m = m >> 1;
            q = q + 1;
         end
         if (m == 0) return {s, 31'b0};
         if (!m[23]) return {s, 8'd0, m[22:0]};
         if (q + 150 >= 255) return {s, 8'hff, 23'b0};
         return {s, 8'(q + 150), m[22:0]};
      endfunction

      function automatic bit is_nan(fisr_pkg::fp32_type a);
         return a[30:23] == 8'hff && a[22:0] != 0;
      endfunction

      function automatic bit is_inf(fisr_pkg::fp32_type a);
         return a[30:23] == 8'hff && a[22:0] == 0;
      endfunction

      function automatic bit [23:0] sig_of(fisr_pkg::fp32_type a);
         return a[30:23] == 0 ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
      endfunction

      function automatic int exp_of(fisr_pkg::fp32_type a);
         return a[30:23] == 0 ? -149 : int'(a[30:23]) - 150;
      endfunction

      function automatic fisr_pkg::fp32_type fp_mul(fisr_pkg::fp32_type a,
                                                    fisr_pkg::fp32_type b);
         bit s;
         s = a[31] ^ b[31];
         if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
         if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 0 || b[30:0] == 0) return fisr_pkg::CANON_NAN;
            return {s, 8'hff, 23'b0};
         end
         return round_pack(s, 128'(sig_of(a)) * 128'(sig_of(b)), exp_of(a) + exp_of(b));
      endfunction

      function automatic fisr_pkg::fp32_type fp_add(fisr_pkg::fp32_type a,
                                                    fisr_pkg::fp32_type b);
         fisr_pkg::fp32_type t;
         int                 d;
         int                 e;
         bit [127:0]         big;
         bit [127:0]         sml;
         if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
         if (is_inf(a) && is_inf(b)) return a[31] == b[31] ? a : fisr_pkg::CANON_NAN;
         if (is_inf(a)) return a;
         if (is_inf(b)) return b;
         if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
         if (b[30:0] == 0) return a;
         if (a[30:0] == 0) return b;
         if (exp_of(a) < exp_of(b)) begin
            t = a; a = b; b = t;
         end
         d = exp_of(a) - exp_of(b);
         if (d <= 90) begin
            big = 128'(sig_of(a)) << d;
            sml = 128'(sig_of(b));
            e   = exp_of(b);
         end else begin
            big = 128'(sig_of(a)) << 64;
            sml = 1;
            e   = exp_of(a) - 64;
         end
         if (a[31] == b[31]) return round_pack(a[31], big + sml, e);
         if (big == sml) return 32'h0;
         if (big > sml) return round_pack(a[31], big - sml, e);
         return round_pack(b[31], sml - big, e);
      endfunction

      function automatic fisr_pkg::fp32_type rsqrt_newton(fisr_pkg::fp32_type x);
         fisr_pkg::fp32_type half;
         fisr_pkg::fp32_type guess;
         fisr_pkg::fp32_type t2;
         fisr_pkg::fp32_type r;
         half  = fp_mul(fisr_pkg::ONE_HALF, x);
         guess = fisr_pkg::MAGIC_GUESS - {x[31], x[31:1]};
         t2    = fp_mul(fp_mul(half, guess), guess);
         r     = fp_mul(guess, fp_add(fisr_pkg::THREE_HALVES, {~t2[31], t2[30:0]}));
         return is_nan(r) ? fisr_pkg::CANON_NAN : r;
      endfunction

      function void note_operand(fisr_pkg::fp32_type x);
         expected_results.push_back(rsqrt_newton(x));
      endfunction

      function void check_result(fisr_pkg::fp32_type got);
         fisr_pkg::fp32_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: result %h", got);
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %h, got %h", want, got);
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 200;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   fisr_pkg::fp32_type req_operand_bits = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   fisr_pkg::fp32_type rsp_result_bits;

   rsqrt_scoreboard sb = new();
   int idle_pct  = 0;
   int stall_pct = 0;
   bit hold_request = 0;
   int hold_count = 0;
   int quiet_cycles = 0;

   fast_inverse_square_root_unit dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_result_bits);
      if (hold_request && hold_count == 0) begin
         hold_count <= HOLD_CYCLES;
         rsp_stall  <= 1;
      end else if (hold_count > 1) begin
         hold_count <= hold_count - 1;
         rsp_stall  <= 1;
      end else begin
         hold_count <= 0;
         rsp_stall  <= $urandom_range(99) < stall_pct;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(fisr_pkg::fp32_type x);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         req_operand_bits <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1;
      req_operand_bits <= x;
      forever begin
         @(posedge clock);
         if (req_valid && !req_stall) break;
      end
      sb.note_operand(x);
   endtask

   task automatic await_drain();
      req_valid <= 0;
      while (sb.expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic fisr_pkg::fp32_type random_operand();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
      if (pick < 70) return {1'b0, 8'd0, 23'($urandom)};
      if (pick < 75) return {1'($urandom), 8'hff, ($urandom_range(1) ? 23'($urandom) : 23'd0)};
      if (pick < 80) return {1'b1, 8'd0, 23'($urandom)};
      return $urandom;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_item(random_operand());
      await_drain();
   endtask

   fisr_pkg::fp32_type directed[] = '{
      32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
      32'h7f800001, 32'hffffffff, 32'h00000001, 32'h007fffff, 32'h00800000,
      32'h3f800000, 32'h40800000, 32'h7f7fffff, 32'h3e800000, 32'hbf800000,
      32'h5f3759df, 32'hff7fffff, 32'h80000001, 32'hc0000000, 32'h40000000,
      32'h807fffff, 32'h3effffff, 32'haaaaaaaa, 32'h55555555
   };

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_item(directed[i]);
      await_drain();

      // long receiver hold-off while items keep coming
      hold_request <= 1;
      @(posedge clock);
      hold_request <= 0;
      for (int i = 0; i < 60; i++) send_item(random_operand());
      await_drain();

      random_phase(190);
      idle_pct = 65;
      random_phase(190);
      idle_pct = 0;
      stall_pct = 65;
      random_phase(190);
      idle_pct = 32;
      stall_pct = 32;
      random_phase(190);
      idle_pct = 0;
      stall_pct = 0;
      repeat (fisr_pkg::NUM_STAGES + 20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== fast_inverse_square_root_unit.f =====
sv/fisr_pkg.sv
sv/fisr_fmul.sv
sv/fisr_fadd.sv
sv/fast_inverse_square_root_unit.sv
dv/tb.sv
